// ===== rtl/olist_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// olist_pkg
// Shared sizes, codes and types of the ordered list engine.
// ----------------------------------------------------------------------------
package olist_pkg;

	localparam int CAP    = 16;
	localparam int IDX_W  = (CAP > 1) ? $clog2(CAP) : 1;
	localparam int LEN_W  = $clog2(CAP + 1);
	localparam int DATA_W = 32;
	localparam int ACT_W  = 4;
	localparam int POS_W  = 8;
	localparam int STAT_W = 2;
	localparam int CNT_W  = 9;
	localparam int CMP_W  = (LEN_W > POS_W) ? LEN_W : POS_W;

	typedef logic [CMP_W-1:0] cmp_t;

	localparam logic [ACT_W-1:0] ACT_INS_HEAD = 4'd0;
	localparam logic [ACT_W-1:0] ACT_INS_TAIL = 4'd1;
	localparam logic [ACT_W-1:0] ACT_INS_AT   = 4'd2;
	localparam logic [ACT_W-1:0] ACT_DEL_HEAD = 4'd3;
	localparam logic [ACT_W-1:0] ACT_DEL_AT   = 4'd4;
	localparam logic [ACT_W-1:0] ACT_DEL_TAIL = 4'd5;
	localparam logic [ACT_W-1:0] ACT_SEARCH   = 4'd6;
	localparam logic [ACT_W-1:0] ACT_SORT     = 4'd7;
	localparam logic [ACT_W-1:0] ACT_READ     = 4'd8;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

	typedef enum logic [1:0] {
		C_HOLD,
		C_INS,
		C_DEL,
		C_SORT
	} cell_op_t;

	// Broadcast to every cell of the row in each cycle.
	typedef struct packed {
		cell_op_t                  op;
		logic                      phase;
		cmp_t                      pos;
		logic [LEN_W-1:0]          len;
		logic signed [DATA_W-1:0]  value;
	} cell_cmd_t;

endpackage : olist_pkg
`default_nettype wire

// ===== rtl/olist_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// olist_req_if / olist_rsp_if
// Valid/ready channels for operation requests and their results.
// ----------------------------------------------------------------------------
interface olist_req_if
	import olist_pkg::*;
	();
	logic                      valid;
	logic                      ready;
	logic [ACT_W-1:0]          action;
	logic signed [DATA_W-1:0]  value;
	logic [POS_W-1:0]          position;

	modport source (output valid, action, value, position, input ready);
	modport sink   (input valid, action, value, position, output ready);
endinterface : olist_req_if

interface olist_rsp_if
	import olist_pkg::*;
	();
	logic                      valid;
	logic                      ready;
	logic [STAT_W-1:0]         status;
	logic                      found;
	logic signed [DATA_W-1:0]  value_out;
	logic [CNT_W-1:0]          count;

	modport source (output valid, status, found, value_out, count, input ready);
	modport sink   (input valid, status, found, value_out, count, output ready);
endinterface : olist_rsp_if
`default_nettype wire

// ===== rtl/olist_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// olist_cell
// One list slot: holds an entry, shifts with its neighbors and takes part
// in odd-even compare-exchange passes.
// ----------------------------------------------------------------------------
module olist_cell
	import olist_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic [IDX_W-1:0]          idx,
	input  wire cell_cmd_t                 cmd,
	input  wire logic signed [DATA_W-1:0]  left_data,
	input  wire logic signed [DATA_W-1:0]  right_data,
	output logic signed [DATA_W-1:0]       data,
	output logic                           hit
);

	logic signed [DATA_W-1:0] data_q;
	logic signed [DATA_W-1:0] data_d;
	cmp_t idx_c;
	cmp_t len_c;
	logic live;
	logic pair_right;
	logic pair_left;

	assign idx_c = cmp_t'(idx);
	assign len_c = cmp_t'(cmd.len);
	assign live  = idx_c < len_c;

	// A pair (i, i+1) is exchanged when i has the parity of the pass.
	assign pair_right = (idx[0] == cmd.phase) && ((idx_c + cmp_t'(1)) < len_c);
	assign pair_left  = (idx[0] != cmd.phase) && (idx_c != '0) && live;

	always_comb begin
		data_d = data_q;
		case (cmd.op)
			C_INS: begin
				if (idx_c == cmd.pos) begin
					data_d = cmd.value;
				end else if (idx_c > cmd.pos) begin
					data_d = left_data;
				end
			end
			C_DEL: begin
				if (idx_c >= cmd.pos) begin
					data_d = right_data;
				end
			end
			C_SORT: begin
				if (pair_right && (data_q > right_data)) begin
					data_d = right_data;
				end else if (pair_left && (left_data > data_q)) begin
					data_d = left_data;
				end
			end
			default: data_d = data_q;
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;
	assign hit  = live && (data_q == cmd.value);

endmodule : olist_cell
`default_nettype wire

// ===== rtl/ordered_list_engine_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_list_engine_top
// Bounded ordered list of signed 32-bit entries held in a row of cells.
// ----------------------------------------------------------------------------
//  Channel  Dir  Beat contents
//  req      in   action, value, position
//  rsp      out  status, found, value_out, count
//
// Every action but sort is done in the cycle its beat is taken; its result
// beat is offered from the next cycle on. Sort runs CAP odd-even
// transposition passes, one per cycle.
// One request is in flight at a time; a new beat is taken while the last
// result still waits, as long as that result is taken in the same cycle.
// Reset clears the length; the entry registers are not reset.
// ----------------------------------------------------------------------------
module ordered_list_engine_top
	import olist_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	olist_req_if.sink   req,
	olist_rsp_if.source rsp
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SORT,
		S_DONE
	} state_t;

	state_t                    state_q;
	logic [IDX_W-1:0]          pass_q;
	logic [LEN_W-1:0]          len_q;
	logic                      rsp_valid_q;
	logic [STAT_W-1:0]         status_q;
	logic                      found_q;
	logic signed [DATA_W-1:0]  value_out_q;
	logic [CNT_W-1:0]          count_q;

	cell_cmd_t                 cmd;
	logic signed [DATA_W-1:0]  cell_data [CAP];
	logic [CAP-1:0]            cell_hit;

	logic                      slot_free;
	logic                      accept;
	logic                      full;
	logic                      empty;
	cmp_t                      pos_c;
	cmp_t                      len_c;
	logic [STAT_W-1:0]         status_d;
	logic                      found_d;
	logic signed [DATA_W-1:0]  value_out_d;
	logic [LEN_W-1:0]          len_d;
	cell_op_t                  op_d;
	cmp_t                      op_pos_d;

	assign slot_free = !rsp_valid_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE) && slot_free;
	assign accept    = req.valid && req.ready;

	assign full  = len_q == LEN_W'(CAP);
	assign empty = len_q == '0;
	assign pos_c = cmp_t'(req.position);
	assign len_c = cmp_t'(len_q);

	always_comb begin
		status_d    = ST_OK;
		found_d     = 1'b0;
		value_out_d = '0;
		len_d       = len_q;
		op_d        = C_HOLD;
		op_pos_d    = '0;
		unique case (req.action)
			ACT_INS_HEAD, ACT_INS_TAIL, ACT_INS_AT: begin
				if (req.action == ACT_INS_HEAD) begin
					op_pos_d = '0;
				end else if (req.action == ACT_INS_TAIL) begin
					op_pos_d = len_c;
				end else begin
					op_pos_d = pos_c;
				end
				if (full) begin
					status_d = ST_FULL;
				end else if (op_pos_d > len_c) begin
					status_d = ST_RANGE;
				end else begin
					op_d  = C_INS;
					len_d = len_q + LEN_W'(1);
				end
			end
			ACT_DEL_HEAD, ACT_DEL_AT, ACT_DEL_TAIL: begin
				if (req.action == ACT_DEL_HEAD) begin
					op_pos_d = '0;
				end else if (req.action == ACT_DEL_TAIL) begin
					op_pos_d = len_c - cmp_t'(1);
				end else begin
					op_pos_d = pos_c;
				end
				if (empty) begin
					status_d = ST_EMPTY;
				end else if (op_pos_d >= len_c) begin
					status_d = ST_RANGE;
				end else begin
					op_d  = C_DEL;
					len_d = len_q - LEN_W'(1);
				end
			end
			ACT_SEARCH: begin
				found_d = |cell_hit;
			end
			ACT_READ: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else if (pos_c >= len_c) begin
					status_d = ST_RANGE;
				end else begin
					value_out_d = cell_data[pos_c[IDX_W-1:0]];
				end
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	// The row sees the decoded request while idle and the pass phase while sorting.
	always_comb begin
		cmd.value = req.value;
		cmd.len   = len_q;
		cmd.phase = pass_q[0];
		cmd.pos   = op_pos_d;
		cmd.op    = C_HOLD;
		if (state_q == S_SORT) begin
			cmd.op = C_SORT;
		end else if (accept) begin
			cmd.op = op_d;
		end
	end

	for (genvar i = 0; i < CAP; i++) begin : g_cell
		logic signed [DATA_W-1:0] left_w;
		logic signed [DATA_W-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = cell_data[i-1];
		end
		if (i == CAP - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = cell_data[i+1];
		end

		olist_cell u_cell (
			.clk        (clk),
			.idx        (IDX_W'(i)),
			.cmd        (cmd),
			.left_data  (left_w),
			.right_data (right_w),
			.data       (cell_data[i]),
			.hit        (cell_hit[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pass_q      <= '0;
			len_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						len_q <= len_d;
						if (req.action == ACT_SORT) begin
							state_q <= S_SORT;
							pass_q  <= '0;
						end else begin
							rsp_valid_q <= 1'b1;
							status_q    <= status_d;
							found_q     <= found_d;
							value_out_q <= value_out_d;
							count_q     <= CNT_W'(len_d);
						end
					end
				end
				S_SORT: begin
					pass_q <= pass_q + IDX_W'(1);
					if (pass_q == IDX_W'(CAP - 1)) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (slot_free) begin
						state_q     <= S_IDLE;
						rsp_valid_q <= 1'b1;
						status_q    <= ST_OK;
						found_q     <= 1'b0;
						value_out_q <= '0;
						count_q     <= CNT_W'(len_q);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.status    = status_q;
	assign rsp.found     = found_q;
	assign rsp.value_out = value_out_q;
	assign rsp.count     = count_q;

endmodule : ordered_list_engine_top
`default_nettype wire
